FILE: sv/itbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_pkg
// Shared types and constants for the integer to base digits converter.
// ----------------------------------------------------------------------------
package itbd_pkg;

   localparam int VALUE_W     = 32;
   localparam int SYMBOL_W    = 8;
   localparam int BASE_LEN_W  = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int SYM_COUNT   = 16;
   localparam int SYM_SEL_W   = 4;

   // divider retires STEP_BITS dividend bits per cycle
   localparam int STEP_BITS   = 8;
   localparam int DIV_STEPS   = VALUE_W / STEP_BITS;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   localparam logic [BASE_LEN_W-1:0] BASE_LEN_RESET = 5'd10;
   localparam logic [SYMBOL_W-1:0]   MINUS_SYMBOL   = 8'h2D;

   typedef struct packed {
      logic start;
      logic div_step;
      logic rd_first;
      logic rd_next;
      logic load_sign;
      logic load_digit;
   } itbd_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic negative;
      logic ptr_zero;
      logic out_free;
   } itbd_status_type;

   function automatic logic [SYMBOL_W-1:0] sym_of(
      input logic [CSR_DATA_W-1:0] sym_low,
      input logic [CSR_DATA_W-1:0] sym_high,
      input logic [SYM_SEL_W-1:0]  digit
   );
      logic [2*CSR_DATA_W-1:0] all_syms;
      all_syms = {sym_high, sym_low};
      return all_syms[digit*SYMBOL_W +: SYMBOL_W];
   endfunction

endpackage

FILE: sv/itbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_ctrl
// Sequencer: conversion, digit readback, sign and digit emission.
// ----------------------------------------------------------------------------
module itbd_ctrl import itbd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  itbd_status_type status,
   output itbd_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.conv_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.rd_first = 1'b1;
            state_in     = status.negative ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.load_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_digit = 1'b1;
               if (status.ptr_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/itbd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itbd_dp
// Datapath: CSRs, radix divider, digit store and result register.
// ----------------------------------------------------------------------------
module itbd_dp import itbd_pkg::*; #(
   parameter int MAX_BASE   = 16,
   parameter int MAX_DIGITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SYMBOL_W-1:0]       rsp_symbol,
   output logic                      rsp_last,
   input  itbd_cmd_type              cmd,
   output itbd_status_type           status
);

   localparam int RW = $clog2(MAX_BASE + 1);
   localparam int DW = $clog2(MAX_BASE);
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);

   logic [BASE_LEN_W-1:0] base_len_ff;
   logic [CSR_DATA_W-1:0] sym_low_ff;
   logic [CSR_DATA_W-1:0] sym_high_ff;

   logic [RW-1:0]         radix_ff;
   logic [RW-1:0]         radix_in;
   logic [VALUE_W-1:0]    x_ff;
   logic [VALUE_W-1:0]    x_in;
   logic [RW-1:0]         rem_ff;
   logic [RW-1:0]         rem_in;
   logic [STEP_CNT_W-1:0] step_ff;
   logic [CW-1:0]         count_ff;
   logic [AW-1:0]         ptr_ff;
   logic [AW-1:0]         rd_addr;
   logic                  neg_ff;
   logic                  digit_end;
   logic                  count_full;
   logic [CW-1:0]         count_m1;
   logic [VALUE_W-1:0]    raw;

   logic [DW-1:0]         digit_mem [MAX_DIGITS];
   logic [DW-1:0]         rd_data_ff;

   logic                  rsp_valid_ff;
   logic [SYMBOL_W-1:0]   rsp_symbol_ff;
   logic                  rsp_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff <= BASE_LEN_RESET;
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_LENGTH:  base_len_ff <= csr_data[BASE_LEN_W-1:0];
            CSR_SYMBOLS_LOW:  sym_low_ff  <= csr_data;
            CSR_SYMBOLS_HIGH: sym_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // radix saturates to [2, MAX_BASE]
   always_comb begin
      priority if (base_len_ff < BASE_LEN_W'(2)) begin
         radix_in = RW'(2);
      end else if (base_len_ff > BASE_LEN_W'(MAX_BASE)) begin
         radix_in = RW'(MAX_BASE);
      end else begin
         radix_in = RW'(base_len_ff);
      end
   end

   // restoring division, STEP_BITS quotient bits per cycle shifted into x
   always_comb begin
      logic [RW:0]           trial;
      logic [RW-1:0]         r;
      logic [STEP_BITS-1:0]  qbits;
      r = rem_ff;
      qbits = '0;
      for (int j = 0; j < STEP_BITS; j++) begin
         trial = {r, x_ff[VALUE_W-1-j]};
         if (trial >= {1'b0, radix_ff}) begin
            trial = trial - {1'b0, radix_ff};
            qbits[STEP_BITS-1-j] = 1'b1;
         end
         r = trial[RW-1:0];
      end
      rem_in = r;
      x_in   = {x_ff[VALUE_W-STEP_BITS-1:0], qbits};
   end

   assign digit_end  = (step_ff == STEP_CNT_W'(DIV_STEPS - 1));
   assign count_full = (count_ff == CW'(MAX_DIGITS - 1));
   assign count_m1   = count_ff - CW'(1);
   assign raw        = req_value;
   assign rd_addr    = cmd.rd_first ? count_m1[AW-1:0] : (ptr_ff - AW'(1));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff     <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
         neg_ff   <= raw[VALUE_W-1];
         radix_ff <= radix_in;
         rem_ff   <= '0;
         step_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.div_step) begin
         x_ff    <= x_in;
         step_ff <= step_ff + STEP_CNT_W'(1);
         if (digit_end) begin
            rem_ff   <= '0;
            count_ff <= count_ff + CW'(1);
         end else begin
            rem_ff <= rem_in;
         end
      end
      if (cmd.rd_first || cmd.rd_next) begin
         ptr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && digit_end) begin
         digit_mem[count_ff[AW-1:0]] <= rem_in[DW-1:0];
      end
      if (cmd.rd_first || cmd.rd_next) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_sign || cmd.load_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sign) begin
         rsp_symbol_ff <= MINUS_SYMBOL;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.load_digit) begin
         rsp_symbol_ff <= sym_of(sym_low_ff, sym_high_ff, SYM_SEL_W'(rd_data_ff));
         rsp_last_ff   <= (ptr_ff == '0);
      end
   end

   // only sampled by the controller while dividing
   assign status.conv_done = digit_end && ((x_in == '0) || count_full);
   assign status.negative  = neg_ff;
   assign status.ptr_zero  = (ptr_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: sv/integer_to_base_digits_core.sv
`timescale 1ns / 1ps
// A request is divided digit by digit, then the first character is loaded; D = digit count.
// Characters then stream one per cycle while rsp_ready is high (D, plus one for a minus sign).
// A new request is accepted only once the last character is loaded; the divider
// retires 8 dividend bits per cycle.
// Reset (synchronous): idle, no result pending, base_length 10, symbols 0.
// ----------------------------------------------------------------------------
// integer_to_base_digits_core
// Signed integer to symbol text in a configurable radix, MSD first.
// ----------------------------------------------------------------------------
module integer_to_base_digits_core import itbd_pkg::*; #(
   parameter int MAX_BASE   = 16,
   parameter int MAX_DIGITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SYMBOL_W-1:0]       rsp_symbol,
   output logic                      rsp_last
);

   itbd_cmd_type    cmd;
   itbd_status_type status;

   itbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   itbd_dp #(
      .MAX_BASE   (MAX_BASE),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_to_base_digits_core: a directed table of
// extreme values and radix corner cases, then randomised phases with fresh
// radix and symbol settings, every character checked against a predictor or typed text.
// ----------------------------------------------------------------------------
module testbench;
   import itbd_pkg::*;

   localparam int MAX_BASE      = 16;
   localparam int MAX_DIGITS    = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 200;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_CSR, ROW_VALUE} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   data;
      logic [VALUE_W-1:0]      value;
      string                   text;
   } stim_row_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } char_exp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SYMBOL_W-1:0]       rsp_symbol;
   logic                      rsp_last;

   logic [BASE_LEN_W-1:0]     model_base_len = BASE_LEN_RESET;
   logic [CSR_DATA_W-1:0]     model_sym_lo = '0;
   logic [CSR_DATA_W-1:0]     model_sym_hi = '0;

   char_exp_type              pending_chars[$];
   string                     typed_texts[$];
   stim_row_type              stim_rows[$];

   int                        errors = 0;
   int                        quiet_cycles = 0;
   bit                        gaps_on = 1'b0;
   logic                      stall_on = 1'b0;
   int                        hold_requests = 0;
   int                        holds_served = 0;
   int                        hold_left = 0;
   int                        stall_left = 0;

   always #5 clock = ~clock;

   integer_to_base_digits_core #(
      .MAX_BASE   (MAX_BASE),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

   function automatic void predict_text(input logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0]      mag;
      logic [31:0]             radix;
      logic [3:0]              digits[$];
      logic [2*CSR_DATA_W-1:0] syms;
      char_exp_type            want;
      int                      sel;
      radix = 32'(model_base_len);
      if (radix < 2) radix = 2;
      if (radix > MAX_BASE) radix = MAX_BASE;
      mag = raw[VALUE_W-1] ? -raw : raw;
      do begin
         digits.push_back(4'(mag % radix));
         mag = mag / radix;
      end while (mag != 0 && digits.size() < MAX_DIGITS);
      if (raw[VALUE_W-1]) begin
         want.symbol = MINUS_SYMBOL;
         want.last = 1'b0;
         pending_chars.push_back(want);
      end
      syms = {model_sym_hi, model_sym_lo};
      while (digits.size() > 0) begin
         sel = int'(digits.pop_back());
         want.symbol = syms[sel*SYMBOL_W +: SYMBOL_W];
         want.last = (digits.size() == 0);
         pending_chars.push_back(want);
      end
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value(input int radix);
      logic [63:0]        p;
      logic [VALUE_W-1:0] v;
      int                 k;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 2 * radix);
         2: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = '1;
               default: v = '0;
            endcase
         end
         default: begin
            p = 1;
            k = $urandom_range(1, 31);
            repeat (k) if (p * radix <= 64'h8000_0000) p = p * radix;
            v = p[VALUE_W-1:0] + $urandom_range(0, 2) - 1;
         end
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.index = index;
      r.data = data;
      r.value = '0;
      r.text = "";
      stim_rows.push_back(r);
   endfunction

   function automatic void add_value(input logic [VALUE_W-1:0] v, input string text);
      stim_row_type r;
      r.kind = ROW_VALUE;
      r.index = '0;
      r.data = '0;
      r.value = v;
      r.text = text;
      stim_rows.push_back(r);
   endfunction

   // empty text: expectation comes from the predictor
   task automatic offer(input logic [VALUE_W-1:0] v, input string text);
      typed_texts.push_back(text);
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0 || typed_texts.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [BASE_LEN_W-1:0] base, input int items,
                            input bit gaps, input bit stalls, input bit hold,
                            input bit pause_mid);
      logic [CSR_DATA_W-1:0] d;
      int                    radix;
      radix = (base < 2) ? 2 : (base > MAX_BASE) ? MAX_BASE : base;
      d = {$urandom, $urandom};
      d[BASE_LEN_W-1:0] = base;
      csr_write(CSR_BASE_LENGTH, d);
      csr_write(CSR_SYMBOLS_LOW, {$urandom, $urandom});
      csr_write(CSR_SYMBOLS_HIGH, {$urandom, $urandom});
      csr_write(CSR_UNUSED, {$urandom, $urandom});
      gaps_on = gaps;
      stall_on <= stalls;
      if (hold) hold_requests <= hold_requests + 1;
      for (int k = 0; k < items; k++) begin
         offer(rand_value(radix), "");
         if (pause_mid && k == items / 2) wait_drained();
         else idle_sender();
      end
   endtask

   // receiver: random stall bursts, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         stall_left <= 0;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(1, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : observe
      char_exp_type want;
      string        text;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_LENGTH:  model_base_len = csr_data[BASE_LEN_W-1:0];
               CSR_SYMBOLS_LOW:  model_sym_lo = csr_data;
               CSR_SYMBOLS_HIGH: model_sym_hi = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected character, expected none, actual symbol %02h last %0b",
                        $time, rsp_symbol, rsp_last);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_symbol !== want.symbol) begin
                  errors++;
                  $display("%0t: symbol mismatch, expected %02h, actual %02h",
                           $time, want.symbol, rsp_symbol);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            text = typed_texts.pop_front();
            if (text.len() == 0) begin
               predict_text(req_value);
            end else begin
               for (int i = 0; i < text.len(); i++) begin
                  want.symbol = text[i];
                  want.last = (i == text.len() - 1);
                  pending_chars.push_back(want);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      gaps_on = 1'b1;
      stall_on <= 1'b1;

      add_value(32'd0, "");
      add_value(32'd7, "");
      add_value(-32'sd5, "");
      add_csr(CSR_SYMBOLS_LOW, 64'h3736_3534_3332_3130);
      add_csr(CSR_SYMBOLS_HIGH, 64'h4645_4443_4241_3938);
      add_value(32'd0, "0");
      add_value(32'h7FFF_FFFF, "2147483647");
      add_value(32'h8000_0000, "-2147483648");
      add_value(-32'sd1, "-1");
      add_value(32'd9, "9");
      add_value(32'd10, "10");
      add_csr(CSR_BASE_LENGTH, 64'd16);
      add_value(32'd255, "FF");
      add_value(32'h8000_0000, "-80000000");
      add_value(-32'sd1, "-1");
      add_value(32'h7FFF_FFFF, "7FFFFFFF");
      add_value(-32'sd3054, "-BEE");
      add_csr(CSR_BASE_LENGTH, 64'd2);
      add_value(32'h8000_0000, "-10000000000000000000000000000000");
      add_value(32'h7FFF_FFFF, "1111111111111111111111111111111");
      add_value(32'd5, "101");
      add_csr(CSR_BASE_LENGTH, 64'd0);
      add_value(32'd6, "110");
      add_csr(CSR_BASE_LENGTH, 64'd1);
      add_value(32'd3, "11");
      add_csr(CSR_BASE_LENGTH, 64'd31);
      add_value(32'd255, "FF");
      add_csr(CSR_BASE_LENGTH, 64'd17);
      add_value(32'd4095, "FFF");
      add_csr(CSR_UNUSED, '1);
      add_value(32'd43981, "ABCD");
      add_csr(CSR_BASE_LENGTH, 64'd8);
      add_value(32'd8, "10");
      add_value(-32'sd9, "-11");

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.kind == ROW_CSR) begin
            csr_write(row.index, row.data);
         end else begin
            offer(row.value, row.text);
            idle_sender();
         end
      end

      run_phase(5'd2, 40, 1'b1, 1'b1, 1'b0, 1'b0);
      run_phase(5'd16, 40, 1'b0, 1'b1, 1'b1, 1'b0);
      for (int p = 0; p < 4; p++) begin
         run_phase(BASE_LEN_W'($urandom_range(0, 31)), 45, p != 2, p[0], 1'b0, p == 1);
      end
      run_phase(BASE_LEN_RESET, 40, 1'b0, 1'b0, 1'b0, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
sv/itbd_pkg.sv
sv/itbd_ctrl.sv
sv/itbd_dp.sv
sv/integer_to_base_digits_core.sv
bench/testbench.sv
